// ----- rtl/core/imhpq_pkg.sv -----
package imhpq_pkg;

   localparam int NUM_VERTICES_DEF = 1024;
   localparam int DIST_BITS_DEF    = 31;
   localparam int VTX_W            = 10;
   localparam int CMD_W            = 2;
   localparam int STAT_W           = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH = 2'd0,
      CMD_POP  = 2'd1,
      CMD_DEC  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE    = 2'd0,
      ST_IGNORED = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_RSVD    = 2'd3
   } status_type;

endpackage

// ----- rtl/core/imhpq_ram.sv -----
module imhpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/core/imhpq_ctrl.sv -----
module imhpq_ctrl #(
   parameter int NUM_VERTICES = imhpq_pkg::NUM_VERTICES_DEF,
   parameter int DIST_BITS    = imhpq_pkg::DIST_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [imhpq_pkg::CMD_W-1:0]   req_cmd,
   input  logic [imhpq_pkg::VTX_W-1:0]   req_vertex,
   input  logic [30:0]                   req_distance,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [imhpq_pkg::STAT_W-1:0]  rsp_status,
   output logic [imhpq_pkg::VTX_W-1:0]   rsp_out_vertex,
   output logic [30:0]                   rsp_out_distance,
   output logic                          rsp_heap_empty
);
   import imhpq_pkg::*;

   localparam int AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
   localparam int CW = $clog2(NUM_VERTICES + 1);
   localparam int SW = DIST_BITS + VTX_W;   // slot word: {distance, vertex}
   localparam int PW = AW + 1;              // position word: {present, slot}
   localparam int OW = (DIST_BITS < 31) ? DIST_BITS : 31;

   typedef enum logic [13:0] {
      S_CLEAR = 14'b00000000000001,
      S_IDLE  = 14'b00000000000010,
      S_PMAP  = 14'b00000000000100,  // position read in flight
      S_DEC   = 14'b00000000001000,  // slot read for decrease
      S_POP0  = 14'b00000000010000,  // root read in flight
      S_POP1  = 14'b00000000100000,  // last read in flight
      S_UPRD  = 14'b00000001000000,  // parent read issued
      S_UPCMP = 14'b00000010000000,
      S_DNL   = 14'b00000100000000,  // left child read in flight
      S_DNR   = 14'b00001000000000,  // right child read in flight
      S_DNCMP = 14'b00010000000000,
      S_WPOS  = 14'b00100000000000,  // second position write of a swap
      S_RESP  = 14'b01000000000000,
      S_DNW   = 14'b10000000000000   // last entry written to root slot
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [VTX_W-1:0] vtx_ff, vtx_in;
   logic [DIST_BITS-1:0] dist_ff, dist_in;
   logic [AW-1:0]    pos_ff, pos_in;      // slot of the moving entry
   logic [AW-1:0]    oth_ff, oth_in;      // parent or chosen child slot
   logic [SW-1:0]    oth_word_ff, oth_word_in;
   logic [SW-1:0]    left_word_ff, left_word_in;
   logic             have_r_ff, have_r_in;
   logic [STAT_W-1:0] st_ff, st_in;
   logic [VTX_W-1:0] ov_ff, ov_in;
   logic [OW-1:0]    od_ff, od_in;
   logic             rv_ff, rv_in;
   logic             pend_dn_ff, pend_dn_in; // after position write, continue down

   // memories
   logic          s_we;  logic [AW-1:0] s_wa, s_ra; logic [SW-1:0] s_wd, s_rd;
   logic          p_we;  logic [AW-1:0] p_wa, p_ra; logic [PW-1:0] p_wd, p_rd;

   imhpq_ram #(.WIDTH(SW), .DEPTH(NUM_VERTICES)) u_slot (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd));
   imhpq_ram #(.WIDTH(PW), .DEPTH(NUM_VERTICES)) u_pos (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));

   logic [DIST_BITS-1:0] rd_dist;
   logic [VTX_W-1:0]     rd_vtx;
   logic [DIST_BITS-1:0] ld_dist;
   logic                 vin_ok;
   logic [CW:0]          lc, rc;
   assign rd_dist = s_rd[SW-1:VTX_W];
   assign rd_vtx  = s_rd[VTX_W-1:0];
   assign ld_dist = left_word_ff[SW-1:VTX_W];
   assign vin_ok  = ({{(32-VTX_W){1'b0}}, req_vertex} < 32'(NUM_VERTICES));
   assign lc = {pos_ff, 1'b1} + (CW+1)'(0);
   assign rc = lc + (CW+1)'(1);

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_out_vertex = ov_ff;
   assign rsp_out_distance = 31'(od_ff);
   assign rsp_heap_empty = (count_ff == '0);

   always_comb begin
      state_in = state_ff; count_in = count_ff; clr_in = clr_ff;
      cmd_in = cmd_ff; vtx_in = vtx_ff; dist_in = dist_ff;
      pos_in = pos_ff; oth_in = oth_ff; oth_word_in = oth_word_ff;
      left_word_in = left_word_ff; have_r_in = have_r_ff;
      st_in = st_ff; ov_in = ov_ff; od_in = od_ff; pend_dn_in = pend_dn_ff;
      rv_in = rv_ff && !rsp_ready;
      s_we = 1'b0; s_wa = pos_ff; s_wd = {dist_ff, vtx_ff}; s_ra = pos_ff;
      p_we = 1'b0; p_wa = vtx_ff; p_wd = {1'b1, pos_ff}; p_ra = req_vertex[AW-1:0];
      case (state_ff)
         S_CLEAR: begin
            p_we = 1'b1; p_wa = clr_ff; p_wd = '0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(NUM_VERTICES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            s_ra = '0;
            if (req_valid && req_ready) begin
               cmd_in = req_cmd; vtx_in = req_vertex;
               dist_in = DIST_BITS'(req_distance);
               st_in = ST_IGNORED; ov_in = '0; od_in = '0;
               case (cmd_type'(req_cmd))
                  CMD_PUSH, CMD_DEC:
                     state_in = vin_ok ? S_PMAP : S_RESP;
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        st_in = ST_EMPTY; state_in = S_RESP;
                     end else state_in = S_POP0;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_PMAP: begin
            if (cmd_ff == CMD_PUSH) begin
               if (!p_rd[AW]) begin
                  // append at the end, then sift up
                  pos_in = count_ff[AW-1:0];
                  s_we = 1'b1; s_wa = count_ff[AW-1:0];
                  p_we = 1'b1; p_wd = {1'b1, count_ff[AW-1:0]};
                  count_in = count_ff + CW'(1);
                  st_in = ST_DONE;
                  state_in = S_UPRD;
               end else state_in = S_RESP;
            end else begin
               if (p_rd[AW]) begin
                  pos_in = p_rd[AW-1:0];
                  s_ra = p_rd[AW-1:0];
                  state_in = S_DEC;
               end else state_in = S_RESP;
            end
         end
         S_DEC: begin
            if (dist_ff <= rd_dist) begin
               s_we = 1'b1; st_in = ST_DONE; state_in = S_UPRD;
            end else state_in = S_RESP;
         end
         S_UPRD: begin
            if (pos_ff == '0) state_in = S_RESP;
            else begin
               oth_in = (pos_ff - AW'(1)) >> 1;
               s_ra = (pos_ff - AW'(1)) >> 1;
               state_in = S_UPCMP;
            end
         end
         S_UPCMP: begin
            if (dist_ff < rd_dist) begin
               // parent moves down to pos; moving entry to parent slot
               s_we = 1'b1; s_wa = pos_ff; s_wd = s_rd;
               p_we = 1'b1; p_wa = rd_vtx; p_wd = {1'b1, pos_ff};
               pos_in = oth_ff; pend_dn_in = 1'b0;
               state_in = S_WPOS;
            end else state_in = S_RESP;
         end
         S_WPOS: begin
            // moving entry lands at pos_ff
            s_we = 1'b1; p_we = 1'b1;
            if (pend_dn_ff) state_in = S_DNL;
            else state_in = S_UPRD;
            s_ra = lc[AW-1:0];
            have_r_in = (rc < (CW+1)'(count_ff));
            if (pend_dn_ff && !(lc < (CW+1)'(count_ff))) state_in = S_RESP;
         end
         S_POP0: begin
            ov_in = rd_vtx; od_in = OW'(rd_dist); st_in = ST_DONE;
            p_we = 1'b1; p_wa = rd_vtx; p_wd = '0;
            count_in = count_ff - CW'(1);
            s_ra = AW'(count_ff - CW'(1));
            state_in = (count_ff == CW'(1)) ? S_RESP : S_POP1;
         end
         S_POP1: begin
            // last entry to root, then sift down
            vtx_in = rd_vtx; dist_in = rd_dist; pos_in = '0;
            vtx_in = rd_vtx;
            p_we = 1'b0; pend_dn_in = 1'b1;
            s_we = 1'b0;
            state_in = S_DNW;
         end
         S_DNW: begin
            s_we = 1'b1; p_we = 1'b1;
            s_ra = lc[AW-1:0];
            have_r_in = (rc < (CW+1)'(count_ff));
            state_in = (lc < (CW+1)'(count_ff)) ? S_DNL : S_RESP;
         end
         S_DNL: begin
            left_word_in = s_rd;
            s_ra = rc[AW-1:0];
            state_in = S_DNR;
         end
         S_DNR: begin
            // choose smaller child, left on tie
            if (have_r_ff && rd_dist < ld_dist) begin
               oth_word_in = s_rd; oth_in = rc[AW-1:0];
            end else begin
               oth_word_in = left_word_ff; oth_in = lc[AW-1:0];
            end
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            if (oth_word_ff[SW-1:VTX_W] < dist_ff) begin
               s_we = 1'b1; s_wa = pos_ff; s_wd = oth_word_ff;
               p_we = 1'b1; p_wa = oth_word_ff[VTX_W-1:0]; p_wd = {1'b1, pos_ff};
               pos_in = oth_ff; pend_dn_in = 1'b1;
               state_in = S_WPOS;
            end else state_in = S_RESP;
         end
         S_RESP: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; count_ff <= '0; clr_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; clr_ff <= clr_in;
         rv_ff <= rv_in;
      end
      cmd_ff <= cmd_in; vtx_ff <= vtx_in; dist_ff <= dist_in;
      pos_ff <= pos_in; oth_ff <= oth_in; oth_word_ff <= oth_word_in;
      left_word_ff <= left_word_in; have_r_ff <= have_r_in;
      st_ff <= st_in; ov_ff <= ov_in; od_ff <= od_in; pend_dn_ff <= pend_dn_in;
   end

endmodule

// ----- rtl/core/indexed_min_heap_priority_queue.sv -----
// channel | ports                                   | dir
// request | req_valid/ready cmd vertex distance     | in
// result  | rsp_valid/ready status out_vertex       | out
//         | out_distance heap_empty                 |
// One item at a time; sift walks one heap level per step: up by parent read,
// compare and swap writes, down by left and right child reads, compare and
// swap writes. After reset a clearing pass empties the position map; no
// request is taken meanwhile. A stalled result holds the block.
module indexed_min_heap_priority_queue #(
   parameter int NUM_VERTICES = imhpq_pkg::NUM_VERTICES_DEF,
   parameter int DIST_BITS    = imhpq_pkg::DIST_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [imhpq_pkg::CMD_W-1:0]   req_cmd,
   input  logic [imhpq_pkg::VTX_W-1:0]   req_vertex,
   input  logic [30:0]                   req_distance,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [imhpq_pkg::STAT_W-1:0]  rsp_status,
   output logic [imhpq_pkg::VTX_W-1:0]   rsp_out_vertex,
   output logic [30:0]                   rsp_out_distance,
   output logic                          rsp_heap_empty
);
   import imhpq_pkg::*;

   // heap control around slot and position memories
   imhpq_ctrl #(.NUM_VERTICES(NUM_VERTICES), .DIST_BITS(DIST_BITS)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_vertex(req_vertex), .req_distance(req_distance),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_out_vertex(rsp_out_vertex), .rsp_out_distance(rsp_out_distance),
      .rsp_heap_empty(rsp_heap_empty));

endmodule
